FILE: hw/rtl/lhint_pkg.sv
// lhint_pkg: constants and stage types for the use-hint pipeline
// depends on nothing; used by every module under hw/rtl
`timescale 1ns / 1ps

package lhint_pkg;

  // modulus and its centered half
  localparam int unsigned QMod   = 8380417;
  localparam int unsigned QHalf  = (QMod - 1) / 2;

  // rounding pre-add before the shift by 7
  localparam int unsigned PreAdd = 127;

  // gamma2 = (q-1)/88: 44 groups, wrap 43 <-> 0
  localparam int unsigned Mul88  = 11275;
  localparam int unsigned Rnd88  = 1 << 23;
  localparam int unsigned Step88 = 2 * ((QMod - 1) / 88);
  localparam logic [5:0]  MaxHi88 = 6'd43;

  // gamma2 = (q-1)/32: 16 groups, mask 15
  localparam int unsigned Mul32  = 1025;
  localparam int unsigned Rnd32  = 1 << 21;
  localparam int unsigned Step32 = 2 * ((QMod - 1) / 32);

  // mode register codes
  localparam logic Mode88 = 1'b0;
  localparam logic Mode32 = 1'b1;

  // stage 1: rounded coefficient
  typedef struct packed {
    logic        valid;
    logic        mode;
    logic        hint;
    logic [22:0] coef;
    logic [16:0] rnd;
  } s1_t;

  // stage 2: high part estimate
  typedef struct packed {
    logic        valid;
    logic        mode;
    logic        hint;
    logic [22:0] coef;
    logic [5:0]  hi;
  } s2_t;

  // stage 3: raw low part
  typedef struct packed {
    logic               valid;
    logic               mode;
    logic               hint;
    logic [5:0]         hi;
    logic signed [24:0] lo;
  } s3_t;

endpackage

FILE: hw/rtl/lhint_split.sv
// lhint_split: first two stages, rounding shift and constant-multiply high part
// depends on lhint_pkg
`timescale 1ns / 1ps

module lhint_split (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             mode_i,
  input  logic             hint_i,
  input  logic [22:0]      coef_i,
  output lhint_pkg::s2_t   s2_o
);

  lhint_pkg::s1_t s1_d, s1_q;
  lhint_pkg::s2_t s2_d, s2_q;
  logic [23:0]    sum1;
  logic [30:0]    m88;
  logic [30:0]    m32;

  // stage 1: (a + 127) >> 7
  always_comb begin
    sum1       = {1'b0, coef_i} + 24'(lhint_pkg::PreAdd);
    s1_d.valid = in_valid_i;
    s1_d.mode  = mode_i;
    s1_d.hint  = hint_i;
    s1_d.coef  = coef_i;
    s1_d.rnd   = sum1[23:7];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  // stage 2: multiply by reciprocal, round, then wrap to zero or mask
  always_comb begin
    m88        = 31'(s1_q.rnd) * 31'(lhint_pkg::Mul88) + 31'(lhint_pkg::Rnd88);
    m32        = 31'(s1_q.rnd) * 31'(lhint_pkg::Mul32) + 31'(lhint_pkg::Rnd32);
    s2_d.valid = s1_q.valid;
    s2_d.mode  = s1_q.mode;
    s2_d.hint  = s1_q.hint;
    s2_d.coef  = s1_q.coef;
    if (s1_q.mode == lhint_pkg::Mode32) begin
      s2_d.hi = {2'b00, m32[25:22]};
    end else if (m88[29:24] > lhint_pkg::MaxHi88) begin
      s2_d.hi = 6'd0;
    end else begin
      s2_d.hi = m88[29:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

FILE: hw/rtl/lhint_low.sv
// lhint_low: third stage, low part a0 = a - a1 * 2 * gamma2
// depends on lhint_pkg
`timescale 1ns / 1ps

module lhint_low (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lhint_pkg::s2_t s2_i,
  output lhint_pkg::s3_t s3_o
);

  lhint_pkg::s3_t s3_d, s3_q;
  logic [24:0]    step;
  logic [24:0]    prod;

  // group width times high part, subtracted from the coefficient
  always_comb begin
    step = (s2_i.mode == lhint_pkg::Mode32) ? 25'(lhint_pkg::Step32)
                                            : 25'(lhint_pkg::Step88);
    prod       = 25'(s2_i.hi) * step;
    s3_d.valid = s2_i.valid;
    s3_d.mode  = s2_i.mode;
    s3_d.hint  = s2_i.hint;
    s3_d.hi    = s2_i.hi;
    s3_d.lo    = $signed({2'b00, s2_i.coef}) - $signed(prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else begin
      s3_q <= s3_d;
    end
  end

  assign s3_o = s3_q;

endmodule

FILE: hw/rtl/lhint_fix.sv
// lhint_fix: last stage, sign of the centered low part and hint correction
// depends on lhint_pkg
`timescale 1ns / 1ps

module lhint_fix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lhint_pkg::s3_t s3_i,
  output logic           valid_o,
  output logic [5:0]     high_bits_o
);

  logic       valid_q;
  logic [5:0] res_d, res_q;
  logic       pos;
  logic [3:0] up16;
  logic [3:0] dn16;

  // centered a0 > 0: raw low in (0, half], or above q so that a0 - q stays positive
  assign pos = ((s3_i.lo > 25'sd0) && (s3_i.lo <= $signed(25'(lhint_pkg::QHalf))))
             || (s3_i.lo > $signed(25'(lhint_pkg::QMod)));

  assign up16 = s3_i.hi[3:0] + 4'd1;
  assign dn16 = s3_i.hi[3:0] - 4'd1;

  // with a hint, move one group up or down, wrapping; without one, keep the estimate
  always_comb begin
    res_d = s3_i.hi;
    if (s3_i.hint) begin
      if (s3_i.mode == lhint_pkg::Mode32) begin
        res_d = {2'b00, pos ? up16 : dn16};
      end else if (pos) begin
        res_d = (s3_i.hi == lhint_pkg::MaxHi88) ? 6'd0 : s3_i.hi + 6'd1;
      end else begin
        res_d = (s3_i.hi == 6'd0) ? lhint_pkg::MaxHi88 : s3_i.hi - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s3_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o     = valid_q;
  assign high_bits_o = res_q;

  // 16-group results stay within the mask
  a_mask16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_i.valid && (s3_i.mode == lhint_pkg::Mode32) |=> (high_bits_o <= 6'd15))
    else $error("16-group result out of range");

  // without a hint the estimate passes unchanged
  a_nohint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_i.valid && !s3_i.hint |=> (high_bits_o == $past(s3_i.hi)))
    else $error("unhinted result changed");

  // a hinted result always differs from its estimate
  a_hint_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_i.valid && s3_i.hint |=> (high_bits_o != $past(s3_i.hi)))
    else $error("hinted result did not move");

endmodule

FILE: hw/rtl/lattice_use_hint.sv
// lattice_use_hint: top level, mode register and the four-stage use-hint pipeline
// depends on lhint_pkg, lhint_split, lhint_low, lhint_fix
`timescale 1ns / 1ps

// How to use this block:
// - request channel: drive coefficient_i and hint_bit_i with start_i high for
//   one cycle; the request is taken at that clock edge. busy_o is always low,
//   so a new request can be issued in every cycle.
// - result channel: valid_o pulses for exactly one cycle with high_bits_o, the
//   corrected high part. The receiver cannot stall; it must take the result
//   in that cycle.
// - a request passes through four register stages (round, reciprocal multiply,
//   low part, correct) before its result shows on valid_o; throughput is one
//   coefficient per cycle.
// - gamma2_mode_we_i writes gamma2_mode_i into the mode register: 0 selects
//   44 groups, 1 selects 16 groups. Write it only with no request in flight.
// - reset (rst_ni low, asynchronous) clears the pipeline valid bits and sets
//   the mode to 44 groups; requests in flight are dropped.

module lattice_use_hint (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [22:0] coefficient_i,
  input  logic        hint_bit_i,
  input  logic        gamma2_mode_we_i,
  input  logic        gamma2_mode_i,
  output logic        valid_o,
  output logic [5:0]  high_bits_o
);

  logic           mode_q, mode_d;
  logic           accept;
  lhint_pkg::s2_t s2;
  lhint_pkg::s3_t s3;

  // pipeline never holds off requests
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // mode register
  assign mode_d = gamma2_mode_we_i ? gamma2_mode_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lhint_pkg::Mode88;
    end else begin
      mode_q <= mode_d;
    end
  end

  // stages one and two
  lhint_split u_split (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .mode_i     (mode_q),
    .hint_i     (hint_bit_i),
    .coef_i     (coefficient_i),
    .s2_o       (s2)
  );

  // stage three
  lhint_low u_low (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s2_i   (s2),
    .s3_o   (s3)
  );

  // stage four, output register
  lhint_fix u_fix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s3_i        (s3),
    .valid_o     (valid_o),
    .high_bits_o (high_bits_o)
  );

  // every request yields a result after the round, multiply, low-part and correct registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 valid_o)
    else $error("result missing after request");

  // no result without a matching request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 4))
    else $error("result without request");

  // results stay within the 44-group range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (high_bits_o <= lhint_pkg::MaxHi88))
    else $error("result out of range");

endmodule
